@@ sv/skf_pkg.sv @@
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and constants for the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int DATA_WIDTH = 32;

  localparam int NOISE_W = 16;   // q, r, start covariance: Q2.14
  localparam int COV_W   = 18;   // covariance: Q4.14
  localparam int GAIN_W  = 16;   // gain: Q0.16
  localparam int DEN_W   = COV_W + 1;
  localparam int REM_W   = DEN_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST = 16'd1638;
  localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 16'd4915;
  localparam logic [NOISE_W-1:0] START_COV_RST     = 16'd164;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_COV     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] gain;
  } div_status_t;

endpackage

@@ sv/skf_divider.sv @@
// ----------------------------------------------------------------------------
// skf_divider
// Restoring divider for the gain: floor(pm * 2^16 / den), one bit per cycle.
// A zero divisor yields a zero gain.
// ----------------------------------------------------------------------------
module skf_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [skf_pkg::COV_W-1:0]  pm,
  input  logic [skf_pkg::DEN_W-1:0]  den,
  output skf_pkg::div_status_t       status
);

  localparam int CNT_W = $clog2(skf_pkg::GAIN_W);

  logic                        busy;
  logic                        done;
  logic [CNT_W-1:0]            cnt;
  logic [skf_pkg::REM_W-1:0]   rem;
  logic [skf_pkg::DEN_W-1:0]   divisor;
  logic [skf_pkg::GAIN_W-1:0]  quot;

  logic [skf_pkg::REM_W-1:0]   rem_shift;
  logic                        take;

  always_comb begin
    rem_shift = {rem[skf_pkg::REM_W-2:0], 1'b0};
    take      = (divisor != '0) && (rem_shift >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(skf_pkg::GAIN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // pm < den unless r is zero, so the partial remainder starts at pm
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= {2'b00, pm};
      divisor <= den;
      quot    <= '0;
    end else if (busy) begin
      rem  <= take ? (rem_shift - {1'b0, divisor}) : rem_shift;
      quot <= {quot[skf_pkg::GAIN_W-2:0], take};
    end
  end

  assign status.done = done;
  assign status.gain = quot;

endmodule

@@ sv/scalar_kalman_filter_top.sv @@
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top
// One-dimensional Kalman filter over signed Q16.16 samples.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//   in       in         in_valid / in_ready    sample
//   out      out        out_valid / out_ready  estimate
//
// A sample runs from accept to result through a setup state, the bit-serial
// gain divider, the radix-4 shift-add gain multiply, and a final state that
// updates the estimate and covariance. in_ready is high only while idle.
// Reset is synchronous; no clearing pass. A result held in the output
// register does not block the next sample; only the final update waits on it.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top #(
  parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [skf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [skf_pkg::NOISE_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [DATA_WIDTH-1:0]        sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [DATA_WIDTH-1:0]        estimate
);

  localparam int PROD_W = DATA_WIDTH + 18;
  localparam int ACC_W  = DATA_WIDTH + 2;
  localparam int MCNT_W = 3;

  skf_pkg::state_t state, state_next;

  logic [skf_pkg::NOISE_W-1:0] process_noise;
  logic [skf_pkg::NOISE_W-1:0] measure_noise;
  logic [skf_pkg::COV_W-1:0]   covariance;
  logic [DATA_WIDTH-1:0]       last_estimate;

  logic [DATA_WIDTH-1:0]       samp;
  logic [skf_pkg::COV_W-1:0]   pm;
  logic [DATA_WIDTH-1:0]       span;
  logic [ACC_W-1:0]            span3;
  logic                        toward_low;
  logic [skf_pkg::GAIN_W-1:0]  gain;
  logic [skf_pkg::GAIN_W-1:0]  gain_sh;
  logic [PROD_W-1:0]           prod;
  logic [MCNT_W-1:0]           mcnt;

  logic                        fin_go;
  logic                        div_start;
  skf_pkg::div_status_t        div_status;

  // ---------------- setup arithmetic ----------------
  logic [skf_pkg::COV_W:0]     pm_sum;
  logic [skf_pkg::COV_W-1:0]   pm_sat;
  logic [skf_pkg::DEN_W-1:0]   den;
  logic signed [DATA_WIDTH:0]  diff;
  logic [DATA_WIDTH:0]         diff_mag;

  always_comb begin
    pm_sum   = {1'b0, covariance} + {3'b000, process_noise};
    pm_sat   = pm_sum[skf_pkg::COV_W] ? '1 : pm_sum[skf_pkg::COV_W-1:0];
    den      = {1'b0, pm_sat} + {3'b000, measure_noise};
    diff     = $signed({samp[DATA_WIDTH-1], samp})
             - $signed({last_estimate[DATA_WIDTH-1], last_estimate});
    diff_mag = diff[DATA_WIDTH] ? (~diff + 1'b1) : diff;
  end

  // the divider loads at the setup edge, so feed it the live predicted covariance
  skf_divider u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .pm     (pm_sat),
    .den    (den),
    .status (div_status)
  );

  // ---------------- multiply step ----------------
  logic [ACC_W-1:0]  addend;
  logic [ACC_W-1:0]  acc_sum;

  always_comb begin
    case (gain_sh[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = {2'b00, span};
      2'd2:    addend = {1'b0, span, 1'b0};
      2'd3:    addend = span3;
      default: addend = '0;
    endcase
    acc_sum = prod[PROD_W-1:16] + addend;
  end

  // ---------------- final update ----------------
  logic [DATA_WIDTH-1:0]           step_mag;
  logic [DATA_WIDTH-1:0]           est_new;
  logic [skf_pkg::GAIN_W:0]        one_minus;
  logic [skf_pkg::GAIN_W+skf_pkg::COV_W:0] cov_prod;

  always_comb begin
    step_mag  = prod[DATA_WIDTH+15:16]
              + DATA_WIDTH'(toward_low && (prod[15:0] != '0));
    est_new   = toward_low ? (last_estimate - step_mag) : (last_estimate + step_mag);
    one_minus = (skf_pkg::GAIN_W+1)'(1 << skf_pkg::GAIN_W) - {1'b0, gain};
    cov_prod  = one_minus * pm;
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      skf_pkg::ST_IDLE: if (in_valid) state_next = skf_pkg::ST_PREP;
      skf_pkg::ST_PREP: state_next = skf_pkg::ST_DIV;
      skf_pkg::ST_DIV:  if (div_status.done) state_next = skf_pkg::ST_MUL;
      skf_pkg::ST_MUL:  if (mcnt == '1) state_next = skf_pkg::ST_FIN;
      skf_pkg::ST_FIN:  if (fin_go) state_next = skf_pkg::ST_IDLE;
      default:          state_next = skf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == skf_pkg::ST_IDLE);
    div_start = (state == skf_pkg::ST_PREP);
    fin_go    = (state == skf_pkg::ST_FIN) && (!out_valid || out_ready);
    cfg_ready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- filter state and configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= skf_pkg::PROCESS_NOISE_RST;
      measure_noise <= skf_pkg::MEASURE_NOISE_RST;
      covariance    <= {2'b00, skf_pkg::START_COV_RST};
      last_estimate <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          skf_pkg::REG_PROCESS_NOISE: process_noise <= cfg_data;
          skf_pkg::REG_MEASURE_NOISE: measure_noise <= cfg_data;
          skf_pkg::REG_START_COV: begin
            covariance <= {2'b00, cfg_data};
          end
          default: ;
        endcase
      end
      if (fin_go) begin
        last_estimate <= est_new;
        covariance    <= cov_prod[skf_pkg::COV_W+15:16];
      end
    end
  end

  // ---------------- working registers ----------------
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      samp <= sample;
    end
    if (state == skf_pkg::ST_PREP) begin
      pm         <= pm_sat;
      span       <= diff_mag[DATA_WIDTH-1:0];
      toward_low <= diff[DATA_WIDTH];
    end
    if (state == skf_pkg::ST_DIV) begin
      span3 <= {2'b00, span} + {1'b0, span, 1'b0};
      if (div_status.done) begin
        gain    <= div_status.gain;
        gain_sh <= div_status.gain;
        prod    <= '0;
        mcnt    <= '0;
      end
    end
    if (state == skf_pkg::ST_MUL) begin
      // add one radix-4 digit times the distance, then shift down two bits
      prod    <= {2'b00, acc_sum, prod[15:2]};
      gain_sh <= {2'b00, gain_sh[skf_pkg::GAIN_W-1:2]};
      mcnt    <= mcnt + 1'b1;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      estimate <= est_new;
    end
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for scalar_kalman_filter_top.
// Drives samples and register writes over valid/ready channels with random
// gaps and output stalls. An in-bench fixed-point filter model predicts each
// estimate, and every output beat is compared in order against it.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import skf_pkg::*;

  typedef logic signed [DATA_WIDTH-1:0] sample_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    logic [NOISE_W-1:0]   data;
  } reg_write_t;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1750;
  localparam int PHASES = 7;
  localparam int STEADY_PHASE = 2;
  localparam int HOLD_AT = 1000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [COV_W:0] COV_MAX = (1 << COV_W) - 1;
  localparam sample_t S_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [NOISE_W-1:0] NOISE_MAX = '1;

  class kalman_scoreboard;
    logic [NOISE_W-1:0] q;
    logic [NOISE_W-1:0] r;
    logic [COV_W-1:0]   cov;
    sample_t            est;
    sample_t            estimates_due[$];
    int                 errors;

    function new();
      q = PROCESS_NOISE_RST;
      r = MEASURE_NOISE_RST;
      cov = COV_W'(START_COV_RST);
      est = '0;
      errors = 0;
    endfunction

    function void load_register(logic [CFG_IDX_W-1:0] idx, logic [NOISE_W-1:0] data);
      case (idx)
        REG_PROCESS_NOISE: q = data;
        REG_MEASURE_NOISE: r = data;
        REG_START_COV: cov = COV_W'(data);
        default: ;  // unmapped index: drop the write
      endcase
    endfunction

    function void note_sample(sample_t s);
      logic [COV_W:0]   pm;
      logic [COV_W+1:0] den;
      logic [35:0]      num;
      logic [35:0]      quo;
      logic [35:0]      prod;
      logic [GAIN_W-1:0] gain;
      longint           diff;
      longint           step;
      pm = {1'b0, cov} + (COV_W+1)'(q);
      if (pm > COV_MAX) pm = COV_MAX;
      den = (COV_W+2)'(pm) + (COV_W+2)'(r);
      if (den == 0) begin
        gain = '0;
      end else begin
        num = 36'(pm) << 16;
        quo = num / 36'(den);
        gain = (quo > 36'hFFFF) ? 16'hFFFF : quo[15:0];
      end
      // arithmetic shift floors, so negative moves round away from the old estimate
      diff = longint'(s) - longint'(est);
      step = (diff * longint'({48'b0, gain})) >>> 16;
      est = sample_t'(longint'(est) + step);
      prod = (36'd65536 - 36'(gain)) * 36'(pm);
      cov = prod[16 +: COV_W];
      estimates_due.push_back(est);
    endfunction

    function void check_estimate(sample_t got);
      sample_t want;
      if (estimates_due.size() == 0) begin
        $display("%0t: unexpected estimate beat, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = estimates_due.pop_front();
        if (got !== want) begin
          $display("%0t: estimate mismatch, expected %h, actual %h", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return estimates_due.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [NOISE_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  sample_t              sample;
  logic                 out_valid;
  logic                 out_ready;
  sample_t              estimate;

  kalman_scoreboard sb = new();
  reg_write_t       reg_writes[$];
  bit               no_gaps;
  sample_t          level;
  int unsigned      cycles = 0;

  scalar_kalman_filter_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .estimate  (estimate)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one sample, sometimes with a random gap ahead of it; valid stays high after the beat.
  task automatic send_sample(input sample_t v);
    if (!no_gaps && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(v);
  endtask

  // Drain the output side so the filter is idle before touching registers.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic flush_reg_writes();
    reg_write_t w;
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data <= w.data;
      do @(posedge clk); while (!cfg_ready);
      sb.load_register(w.idx, w.data);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic set_filter(input logic [NOISE_W-1:0] q, input logic [NOISE_W-1:0] r,
                            input logic [NOISE_W-1:0] p0);
    finish_phase();
    reg_writes.push_back({REG_PROCESS_NOISE, q});
    reg_writes.push_back({REG_MEASURE_NOISE, r});
    reg_writes.push_back({REG_START_COV, p0});
    flush_reg_writes();
  endtask

  function automatic logic [NOISE_W-1:0] pick_noise();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return NOISE_MAX;
      2, 3: return NOISE_W'($urandom_range(1, 2000));
      default: return NOISE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic sample_t pick_sample();
    sample_t near;
    near = sb.est;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return sample_t'($urandom);
      4, 5: return near + sample_t'($urandom_range(0, 2000)) - sample_t'(1000);
      6: return $urandom_range(0, 1) ? S_MAX : S_MIN;
      7: begin
        if ($urandom_range(0, 7) == 0) level = sample_t'($urandom);
        return level;
      end
      default: return sample_t'($urandom_range(0, 32 * 65536)) - sample_t'(16 * 65536);
    endcase
  endfunction

  // Result side: random stalls, plus one long hold-off that backs up the input.
  initial begin
    int seen;
    int hold_left;
    seen = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        sb.check_estimate(estimate);
        seen++;
        if (seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_gaps || ($urandom_range(0, 99) >= 31);
      end
    end
  end

  initial begin
    int first;
    no_gaps = 1'b0;
    level = '0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    sample <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_PROCESS_NOISE;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, field extremes and full-scale swings
    send_sample('0);
    send_sample(sample_t'(32'h0001_0000));
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample(-1);
    send_sample(1);
    send_sample(sample_t'(32'hFFFF_0000));

    // zero noise with zero covariance: gain must stay zero
    set_filter('0, '0, '0);
    finish_phase();
    reg_writes.push_back({REG_UNUSED, NOISE_MAX});
    flush_reg_writes();
    send_sample(S_MAX);
    send_sample(S_MIN);

    // zero measurement noise with covariance present: gain saturates
    finish_phase();
    reg_writes.push_back({REG_PROCESS_NOISE, NOISE_MAX});
    flush_reg_writes();
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample(sample_t'(32'h1234_5678));

    // largest noise and covariance, pushing the predicted covariance up
    set_filter(NOISE_MAX, NOISE_MAX, NOISE_MAX);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample('0);
    send_sample(S_MAX);

    set_filter('0, 16'd1, 16'd1);
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample(sample_t'(12345));

    set_filter('0, NOISE_MAX, 16'd1);
    send_sample(S_MAX);
    send_sample(S_MIN);

    for (int p = 0; p < PHASES; p++) begin
      finish_phase();
      first = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
        case ((first + k) % 3)
          0: if ($urandom_range(0, 99) < 85)
               reg_writes.push_back({REG_PROCESS_NOISE, pick_noise()});
          1: if ($urandom_range(0, 99) < 85)
               reg_writes.push_back({REG_MEASURE_NOISE, pick_noise()});
          default: if ($urandom_range(0, 99) < 60)
               reg_writes.push_back({REG_START_COV, pick_noise()});
        endcase
      end
      if ($urandom_range(0, 4) == 0)
        reg_writes.push_back({REG_UNUSED, NOISE_W'($urandom)});
      flush_reg_writes();
      no_gaps = (p == STEADY_PHASE);
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) send_sample(pick_sample());
    end
    no_gaps = 1'b0;
    finish_phase();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ scalar_kalman_filter_top.f @@
sv/skf_pkg.sv
sv/skf_divider.sv
sv/scalar_kalman_filter_top.sv
tb/tb_top.sv
